/* design/mmr_pkg.sv */
package mmr_pkg;

  localparam int unsigned GroupSlotsDef      = 16;
  localparam int unsigned MembersPerGroupDef = 16;

  localparam logic [1:0] CmdAdd     = 2'd0;
  localparam logic [1:0] CmdJoin    = 2'd1;
  localparam logic [1:0] CmdLeave   = 2'd2;
  localparam logic [1:0] CmdForward = 2'd3;

  localparam logic [1:0] KindCopy  = 2'd0;
  localparam logic [1:0] KindOrig  = 2'd1;
  localparam logic [1:0] KindReply = 2'd2;

  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StGrpScan,
    StGrpChk,
    StMemRd,
    StMemChk,
    StDecide,
    StCopyRd,
    StCopyOut,
    StShiftRd,
    StShiftWr,
    StOrig,
    StReply
  } state_e;

endpackage

/* design/mmr_ram.sv */
module mmr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/multicast_membership_replicator_core.sv */
// Multicast group table with packet replication. One transaction is taken
// while stall_o is low; the block then stays busy until its last result has
// been loaded into the output register. Groups are found by a linear walk of
// the slot table, one slot a cycle through a single 128-bit comparator; a
// receiver search walks the group's list one entry at a time, a read state then
// a check state, through the same comparator and the registered-read member RAM.
// Forward yields each copy through a read state and an output state, both held
// while the output is stalled, and a leave compacts the list one entry at a
// time through a read state and a write state.
module multicast_membership_replicator_core #(
  parameter int unsigned GroupSlots      = mmr_pkg::GroupSlotsDef,
  parameter int unsigned MembersPerGroup = mmr_pkg::MembersPerGroupDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] group_high_i,
  input  logic [63:0] group_low_i,
  input  logic [63:0] member_high_i,
  input  logic [63:0] member_low_i,
  input  logic [7:0]  hop_limit_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [63:0] dest_high_o,
  output logic [63:0] dest_low_o,
  output logic [7:0]  hop_out_o,
  output logic        last_o
);

  localparam int unsigned SlotW = (GroupSlots > 1) ? $clog2(GroupSlots) : 1;
  localparam int unsigned CntW  = $clog2(MembersPerGroup + 1);
  localparam int unsigned SCntW = $clog2(GroupSlots + 1);
  localparam int unsigned Depth = GroupSlots * MembersPerGroup;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  mmr_pkg::state_e state_q, state_d;

  logic [1:0]   cmd_q;
  logic [127:0] grp_q, mem_q;
  logic [7:0]   hop_q;

  logic [GroupSlots-1:0] used_q;
  logic [127:0]          sgrp_q [GroupSlots];
  logic [CntW-1:0]       cnt_q  [GroupSlots];

  logic [SCntW-1:0] scan_q, scan_d;
  logic             found_q, found_d;
  logic             free_ok_q, free_ok_d;
  logic [SlotW-1:0] slot_q, slot_d, free_q, free_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             mfound_q, mfound_d;

  logic        ovalid_q, ovalid_d;
  logic [1:0]  okind_q, okind_d, ostat_q, ostat_d;
  logic [127:0] odest_q, odest_d;
  logic [7:0]  ohop_q, ohop_d;
  logic        olast_q, olast_d;
  logic [1:0]  status_q, status_d;

  logic         ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [127:0] ram_wdata, ram_rdata;

  logic [127:0] cmp_a, cmp_b;
  logic         cmp_eq;

  logic         grp_wr, cnt_wr, used_set, used_clr;
  logic [CntW-1:0] cnt_wval;

  logic [SlotW-1:0] scan_idx;
  logic [CntW-1:0]  cur_cnt;

  assign scan_idx = scan_q[SlotW-1:0];
  assign cur_cnt  = cnt_q[slot_q];

  // the one shared comparator
  assign cmp_eq = (cmp_a == cmp_b);

  function automatic logic [AW-1:0] maddr(input logic [SlotW-1:0] s,
                                          input logic [CntW-1:0] k);
    return AW'(s) * AW'(MembersPerGroup) + AW'(k);
  endfunction

  mmr_ram #(.Width(128), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign stall_o     = (state_q != mmr_pkg::StIdle);
  assign valid_o     = ovalid_q;
  assign kind_o      = okind_q;
  assign status_o    = ostat_q;
  assign dest_high_o = odest_q[127:64];
  assign dest_low_o  = odest_q[63:0];
  assign hop_out_o   = ohop_q;
  assign last_o      = olast_q;

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    found_d   = found_q;
    free_ok_d = free_ok_q;
    slot_d    = slot_q;
    free_d    = free_q;
    k_d       = k_q;
    mfound_d  = mfound_q;
    status_d  = status_q;
    ovalid_d  = ovalid_q;
    okind_d   = okind_q;
    ostat_d   = ostat_q;
    odest_d   = odest_q;
    ohop_d    = ohop_q;
    olast_d   = olast_q;
    ram_we    = 1'b0;
    ram_waddr = maddr(slot_q, k_q);
    ram_wdata = mem_q;
    ram_raddr = maddr(slot_q, k_q);
    cmp_a     = grp_q;
    cmp_b     = sgrp_q[scan_idx];
    grp_wr    = 1'b0;
    cnt_wr    = 1'b0;
    cnt_wval  = cur_cnt;
    used_set  = 1'b0;
    used_clr  = 1'b0;

    if (ovalid_q && !stall_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      mmr_pkg::StIdle: begin
        if (valid_i) begin
          scan_d    = '0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          k_d       = '0;
          mfound_d  = 1'b0;
          status_d  = mmr_pkg::StatDone;
          state_d   = mmr_pkg::StGrpScan;
        end
      end
      mmr_pkg::StGrpScan: begin
        if (scan_q == SCntW'(GroupSlots)) begin
          state_d = mmr_pkg::StDecide;
        end else begin
          if (used_q[scan_idx] && cmp_eq && !found_q) begin
            found_d = 1'b1;
            slot_d  = scan_idx;
          end
          if (!used_q[scan_idx] && !free_ok_q) begin
            free_ok_d = 1'b1;
            free_d    = scan_idx;
          end
          scan_d = scan_q + 1'b1;
        end
      end
      mmr_pkg::StDecide: begin
        k_d = '0;
        case (cmd_q)
          mmr_pkg::CmdForward: begin
            if (found_q && cur_cnt != '0) state_d = mmr_pkg::StCopyRd;
            else state_d = mmr_pkg::StOrig;
          end
          mmr_pkg::CmdAdd: begin
            if (found_q) status_d = mmr_pkg::StatMiss;
            else if (!free_ok_q) status_d = mmr_pkg::StatFull;
            else begin
              grp_wr   = 1'b1;
              used_set = 1'b1;
              cnt_wr   = 1'b1;
              cnt_wval = '0;
            end
            state_d = mmr_pkg::StReply;
          end
          default: begin
            if (!found_q) begin
              if (cmd_q == mmr_pkg::CmdLeave) status_d = mmr_pkg::StatMiss;
              state_d = mmr_pkg::StReply;
            end else if (cur_cnt == '0) begin
              state_d = mmr_pkg::StMemChk;
            end else begin
              state_d = mmr_pkg::StMemRd;
            end
          end
        endcase
      end
      mmr_pkg::StMemRd: begin
        state_d = mmr_pkg::StMemChk;
      end
      mmr_pkg::StMemChk: begin
        cmp_a = mem_q;
        cmp_b = ram_rdata;
        if (k_q != cur_cnt && cmp_eq) begin
          mfound_d = 1'b1;
        end
        if (k_q != cur_cnt && !cmp_eq && k_q + 1'b1 != cur_cnt) begin
          k_d     = k_q + 1'b1;
          state_d = mmr_pkg::StMemRd;
        end else if (cmd_q == mmr_pkg::CmdJoin) begin
          if (k_q != cur_cnt && cmp_eq) status_d = mmr_pkg::StatMiss;
          else if (cur_cnt >= CntW'(MembersPerGroup)) status_d = mmr_pkg::StatFull;
          else begin
            ram_we    = 1'b1;
            ram_waddr = maddr(slot_q, cur_cnt);
            cnt_wr    = 1'b1;
            cnt_wval  = cur_cnt + 1'b1;
          end
          state_d = mmr_pkg::StReply;
        end else begin
          if (k_q != cur_cnt && cmp_eq) begin
            k_d     = k_q + 1'b1;
            state_d = mmr_pkg::StShiftRd;
          end else begin
            status_d = mmr_pkg::StatMiss;
            state_d  = mmr_pkg::StReply;
          end
        end
      end
      mmr_pkg::StShiftRd: begin
        // k_q points at the entry to move down
        if (k_q == cur_cnt) begin
          cnt_wr   = 1'b1;
          cnt_wval = cur_cnt - 1'b1;
          if (cur_cnt == CntW'(1)) used_clr = 1'b1;
          state_d = mmr_pkg::StReply;
        end else begin
          state_d = mmr_pkg::StShiftWr;
        end
      end
      mmr_pkg::StShiftWr: begin
        ram_we    = 1'b1;
        ram_waddr = maddr(slot_q, k_q - 1'b1);
        ram_wdata = ram_rdata;
        k_d       = k_q + 1'b1;
        state_d   = mmr_pkg::StShiftRd;
      end
      mmr_pkg::StCopyRd: begin
        if (!ovalid_q || !stall_i) state_d = mmr_pkg::StCopyOut;
      end
      mmr_pkg::StCopyOut: begin
        if (!ovalid_q || !stall_i) begin
          ovalid_d = 1'b1;
          okind_d  = mmr_pkg::KindCopy;
          ostat_d  = mmr_pkg::StatDone;
          odest_d  = ram_rdata;
          ohop_d   = hop_q + 8'd1;
          olast_d  = 1'b0;
          k_d      = k_q + 1'b1;
          if (k_q + 1'b1 == cur_cnt) state_d = mmr_pkg::StOrig;
          else state_d = mmr_pkg::StCopyRd;
        end
      end
      mmr_pkg::StOrig: begin
        if (!ovalid_q || !stall_i) begin
          ovalid_d = 1'b1;
          okind_d  = mmr_pkg::KindOrig;
          ostat_d  = mmr_pkg::StatDone;
          odest_d  = grp_q;
          ohop_d   = hop_q;
          olast_d  = 1'b1;
          state_d  = mmr_pkg::StIdle;
        end
      end
      mmr_pkg::StReply: begin
        if (!ovalid_q || !stall_i) begin
          ovalid_d = 1'b1;
          okind_d  = mmr_pkg::KindReply;
          ostat_d  = status_q;
          odest_d  = '0;
          ohop_d   = '0;
          olast_d  = 1'b1;
          state_d  = mmr_pkg::StIdle;
        end
      end
      default: state_d = mmr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mmr_pkg::StIdle;
      ovalid_q <= 1'b0;
      used_q   <= '0;
      for (int i = 0; i < GroupSlots; i++) cnt_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (used_set) used_q[free_q] <= 1'b1;
      if (used_clr) used_q[slot_q] <= 1'b0;
      if (cnt_wr) begin
        if (used_set) cnt_q[free_q] <= cnt_wval;
        else cnt_q[slot_q] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmr_pkg::StIdle && valid_i) begin
      cmd_q <= cmd_i;
      grp_q <= {group_high_i, group_low_i};
      mem_q <= {member_high_i, member_low_i};
      hop_q <= hop_limit_i;
    end
    if (grp_wr) sgrp_q[free_q] <= grp_q;
    scan_q    <= scan_d;
    found_q   <= found_d;
    free_ok_q <= free_ok_d;
    slot_q    <= slot_d;
    free_q    <= free_d;
    k_q       <= k_d;
    mfound_q  <= mfound_d;
    status_q  <= status_d;
    okind_q   <= okind_d;
    ostat_q   <= ostat_d;
    odest_q   <= odest_d;
    ohop_q    <= ohop_d;
    olast_q   <= olast_d;
  end

endmodule
